// ----- rtl/jac_pkg.sv -----
// Shared types and constants for the Jacobi symbol block.
// No dependencies; used by jac_rem and jacobi_symbol.

package jac_pkg;

	localparam int unsigned WORD_W = 32;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [$clog2(WORD_W)-1:0] bit_cnt_t;

	// Two's complement codes of the result.
	typedef logic signed [1:0] sym_t;
	localparam sym_t SYM_ZERO = 2'sb00;
	localparam sym_t SYM_POS  = 2'sb01;
	localparam sym_t SYM_NEG  = 2'sb11;

	// Residues of the modulus that decide the sign flips.
	localparam logic [1:0] MOD4_ONE   = 2'd1;
	localparam logic [1:0] MOD4_THREE = 2'd3;
	localparam logic [2:0] MOD8_THREE = 3'd3;
	localparam logic [2:0] MOD8_FIVE  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/jac_rem.sv -----
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on jac_pkg for the word type and the bit counter type.

module jac_rem (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  jac_pkg::word_t dividend,
	input  jac_pkg::word_t divisor,
	output logic          done,
	output jac_pkg::word_t remainder
);
	import jac_pkg::*;

	word_t    rem_q;
	word_t    dvd_q;
	word_t    dvs_q;
	bit_cnt_t cnt_q;
	logic     busy_q;
	logic     done_q;

	logic [WORD_W:0] trial;
	logic [WORD_W:0] diff;

	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it always fits one word.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= diff[WORD_W-1:0];
			else
				rem_q <= trial[WORD_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/jacobi_symbol.sv -----
// Top level of the Jacobi symbol block: sequencer, operand registers, output register.
// Depends on jac_pkg and on jac_rem for the remainder steps.
//
//  channel | beat fields              | handshake
//  input   | value_a, modulus_p       | in_valid / in_ready
//  output  | symbol, bad_modulus      | out_valid / out_ready
//
// One beat is loaded, then each factor of two is stripped in its own step, and
// each Euclid pass takes a swap step and, unless the dividend is already below
// the divisor, a run of the bit-serial remainder unit. An even modulus skips
// the loop and goes straight to the output stage.
// Reset clears the sequencer and the output valid. A stalled output holds the
// finished result while the next input beat is taken and worked on.

module jacobi_symbol (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  value_a,
	input  logic [31:0]         modulus_p,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [1:0]   symbol,
	output logic                bad_modulus
);
	import jac_pkg::*;

	state_t state_q;
	state_t state_d;

	word_t num_q;
	word_t mod_q;
	logic  neg_q;
	sym_t  res_sym_q;
	logic  res_bad_q;

	logic  out_valid_q;
	sym_t  out_sym_q;
	logic  out_bad_q;

	logic  accept;
	logic  do_strip;
	logic  do_swap;
	logic  do_finish;
	logic  div_start;
	logic  div_done;
	logic  out_load;
	logic  small_dvd;
	word_t div_rem;
	word_t a_bits;

	assign a_bits    = word_t'(value_a);
	assign accept    = in_valid && in_ready;
	assign small_dvd = mod_q < num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		do_strip  = 1'b0;
		do_swap   = 1'b0;
		do_finish = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = modulus_p[0] ? ST_LOOP : ST_DONE;
			end
			ST_LOOP: begin
				priority if (num_q == '0) begin
					do_finish = 1'b1;
					state_d   = ST_DONE;
				end else if (!num_q[0]) begin
					do_strip = 1'b1;
				end else begin
					do_swap = 1'b1;
					// Swap now; the old modulus becomes the dividend.
					if (!small_dvd) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_LOOP;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mod_q     <= modulus_p;
			res_bad_q <= !modulus_p[0];
			res_sym_q <= SYM_ZERO;
			if (a_bits[WORD_W-1]) begin
				num_q <= '0 - a_bits;
				neg_q <= modulus_p[1:0] != MOD4_ONE;
			end else begin
				num_q <= a_bits;
				neg_q <= 1'b0;
			end
		end else if (do_strip) begin
			num_q <= {1'b0, num_q[WORD_W-1:1]};
			if (mod_q[2:0] == MOD8_THREE || mod_q[2:0] == MOD8_FIVE)
				neg_q <= !neg_q;
		end else if (do_swap) begin
			num_q <= mod_q;
			mod_q <= num_q;
			if (num_q[1:0] == MOD4_THREE && mod_q[1:0] == MOD4_THREE)
				neg_q <= !neg_q;
		end else if (state_q == ST_DIV && div_done) begin
			num_q <= div_rem;
		end else if (do_finish) begin
			if (mod_q != word_t'(1))
				res_sym_q <= SYM_ZERO;
			else
				res_sym_q <= neg_q ? SYM_NEG : SYM_POS;
		end
	end

	jac_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mod_q),
		.divisor   (num_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sym_q <= res_sym_q;
			out_bad_q <= res_bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = out_sym_q;
	assign bad_modulus = out_bad_q;

endmodule
